// ===== design/mws_pkg.sv =====
// Shared types and constants for the multitrack wavetable sequencer.
package mws_pkg;

    // Datapath widths, sized for the largest sample rate supported
    localparam int DVD_W  = 37;   // divider dividend / quotient
    localparam int DVS_W  = 27;   // divider divisor / remainder
    localparam int DUR_W  = 27;   // note duration in ticks
    localparam int SPP_W  = 18;   // samples per wave period
    localparam int TICK_W = 32;
    localparam int ENV_W  = 16;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int SMP_W  = 11;
    localparam int GAIN_W = 11;
    localparam int SUM_W  = 16;
    localparam int PROD_W = 22;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_REWIND = 2'd2;

    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_PLAY   = 3'd2;
    localparam logic [2:0] REG_OCTAVE = 3'd3;
    localparam logic [2:0] REG_TEMPO  = 3'd4;

    localparam logic [9:0] TEMPO_RESET = 10'd226;

    localparam logic [10:0] SINE_ROM [32] = '{
        11'd1024, 11'd1055, 11'd1250, 11'd1436, 11'd1605, 11'd1753, 11'd1873, 11'd1959,
        11'd2010, 11'd2024, 11'd1998, 11'd1935, 11'd1838, 11'd1709, 11'd1553, 11'd1377,
        11'd1188, 11'd993,  11'd798,  11'd612,  11'd443,  11'd295,  11'd175,  11'd89,
        11'd38,   11'd24,   11'd50,   11'd113,  11'd210,  11'd339,  11'd495,  11'd671
    };

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== design/mws_divider.sv =====
// Radix-2 restoring divider, one quotient bit per clock.
module mws_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mws_pkg::div_req_t req,
    output mws_pkg::div_rsp_t rsp
);
    import mws_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
            dvd_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ~diff[DVS_W+1]};
            rem_reg <= diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/multitrack_wavetable_sequencer.sv =====
// Top level of the multitrack wavetable sequencer.
//
// A word on the input channel is one of three operations. A note write stores
// frequency and beats into the note memory (and with last_entry sets the track
// length); a rewind zeroes every note position. A sample tick walks the tracks
// one after another through a single shared restoring divider and yields one
// mixed_sample word. Each playing, enabled, loaded track needs up to six
// divisions (note duration, next position, samples per period, phase, wave
// index, envelope gain) plus sequencing states; silent ticks skip the tracks
// and the divider. The input is stalled for the whole of that work, while a
// finished word may still wait in the output register. Note memory contents
// are undefined until written; per-track state is cleared by reset.
// Configuration sits on an APB-style port, register n at byte 4*n.
module multitrack_wavetable_sequencer #(
    parameter int TRACKS          = 16,
    parameter int NOTES_PER_TRACK = 64,
    parameter int SAMPLE_RATE_HZ  = 8000
) (
    input  logic        clk,
    input  logic        rst_n,
    // input word channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [3:0]  track,
    input  logic [5:0]  entry_index,
    input  logic [11:0] note_frequency,
    input  logic [3:0]  note_beats,
    input  logic        last_entry,
    // output word channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] mixed_sample,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mws_pkg::*;

    localparam int LOOP_N  = (TRACKS < 16) ? TRACKS : 16;
    localparam int CNT_W   = $clog2(LOOP_N + 1);
    localparam int TRK_W   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int DEPTH   = TRACKS * NOTES_PER_TRACK;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DUR_K   = 60 * SAMPLE_RATE_HZ;
    // active count ceiling; the register cannot exceed 31
    localparam int CNT_CAP = (TRACKS < 31) ? TRACKS : 31;

    localparam logic [ADDR_W-1:0] NPT_A    = ADDR_W'(NOTES_PER_TRACK);
    localparam logic [DVD_W-1:0]  DUR_K_V  = DVD_W'(DUR_K);
    localparam logic [DVD_W-1:0]  SR_V     = DVD_W'(SAMPLE_RATE_HZ);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_RD1, S_DURW, S_ADVW, S_RD2, S_FRQ, S_SPPW,
        S_PHW, S_WIW, S_GW, S_ACC, S_NEXT, S_MIX, S_MIXW, S_OUT
    } state_t;

    // configuration registers
    logic [4:0]  active_reg;
    logic [15:0] mask_reg;
    logic        playing_reg;
    logic        octave_reg;
    logic [9:0]  tempo_reg;

    // sequencer and datapath registers
    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] now_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [SPP_W-1:0]  spp_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SMP_W-1:0]  result_reg;
    logic              out_valid_reg;
    logic [SMP_W-1:0]  mixed_reg;
    div_req_t          div_req_reg;
    div_rsp_t          div_rsp;

    // per-track state
    logic [POS_W-1:0]  pos_reg   [TRACKS];
    logic [TICK_W-1:0] start_reg [TRACKS];
    logic [ENV_W-1:0]  env_reg   [TRACKS];
    logic [LEN_W-1:0]  len_reg   [TRACKS];

    // note memory: {frequency, beats}
    logic [15:0]       note_mem [DEPTH];
    logic [15:0]       rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    logic              in_acc;
    logic              cfg_wr;
    logic [TRK_W-1:0]  trk;
    logic [TRK_W-1:0]  wr_trk;
    logic [4:0]        count;
    logic [TICK_W-1:0] elapsed;
    logic [DUR_W-1:0]  q_dur;
    logic [ENV_W-1:0]  env_cur;
    logic [11:0]       rd_freq;
    logic [3:0]        rd_beats;
    logic              wr_ok;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    assign trk      = TRK_W'(cnt_reg);
    assign wr_trk   = TRK_W'(track);
    assign count    = (active_reg > 5'(CNT_CAP)) ? 5'(CNT_CAP) : active_reg;
    assign rd_addr  = ADDR_W'(trk) * NPT_A + ADDR_W'(pos_reg[trk]);
    assign wr_addr  = ADDR_W'(track) * NPT_A + ADDR_W'(entry_index);
    assign wr_ok    = (track < TRACKS) && (entry_index < NOTES_PER_TRACK);
    assign wr_en    = in_acc && (operation == OP_WRITE) && wr_ok;
    assign rd_freq  = rdata_reg[15:4];
    assign rd_beats = rdata_reg[3:0];
    assign q_dur    = div_rsp.quotient[DUR_W-1:0];
    assign elapsed  = now_reg - start_reg[trk];
    assign env_cur  = env_reg[trk];

    // register read-back
    always_comb
    begin
        case (paddr[4:2])
            REG_ACTIVE: prdata = {27'd0, active_reg};
            REG_MASK:   prdata = {16'd0, mask_reg};
            REG_PLAY:   prdata = {31'd0, playing_reg};
            REG_OCTAVE: prdata = {31'd0, octave_reg};
            REG_TEMPO:  prdata = {22'd0, tempo_reg};
            default:    prdata = '0;
        endcase
    end

    // note memory, read every cycle at the current track's position
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            note_mem[wr_addr] <= {note_frequency, note_beats};
        end
        rdata_reg <= note_mem[rd_addr];
    end

    mws_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            mask_reg      <= '0;
            playing_reg   <= 1'b0;
            octave_reg    <= 1'b0;
            tempo_reg     <= TEMPO_RESET;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            now_reg       <= '0;
            dur_reg       <= '0;
            spp_reg       <= '0;
            prod_reg      <= '0;
            sum_reg       <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            mixed_reg     <= '0;
            div_req_reg   <= '0;
            for (int i = 0; i < TRACKS; i++)
            begin
                pos_reg[i]   <= '0;
                start_reg[i] <= '0;
                env_reg[i]   <= '0;
                len_reg[i]   <= '0;
            end
        end
        else
        begin
            div_req_reg.start <= 1'b0;

            if (cfg_wr)
            begin
                case (paddr[4:2])
                    REG_ACTIVE: active_reg  <= pwdata[4:0];
                    REG_MASK:   mask_reg    <= pwdata[15:0];
                    REG_PLAY:   playing_reg <= pwdata[0];
                    REG_OCTAVE: octave_reg  <= pwdata[0];
                    REG_TEMPO:  tempo_reg   <= pwdata[9:0];
                    default:    ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (operation)
                            OP_WRITE:
                            begin
                                if (wr_ok && last_entry)
                                begin
                                    len_reg[wr_trk] <= LEN_W'(entry_index) + 1'b1;
                                end
                            end
                            OP_REWIND:
                            begin
                                for (int i = 0; i < TRACKS; i++)
                                begin
                                    pos_reg[i] <= '0;
                                end
                            end
                            OP_TICK:
                            begin
                                now_reg    <= tick_reg;
                                tick_reg   <= tick_reg + 1'b1;
                                cnt_reg    <= '0;
                                sum_reg    <= '0;
                                result_reg <= '0;
                                if (playing_reg && (count != 5'd0))
                                begin
                                    state_reg <= S_CHK;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_CHK:
                begin
                    // memory read of this track's note is under way
                    if ((cnt_reg >= count) || (cnt_reg >= LOOP_N))
                    begin
                        state_reg <= S_MIX;
                    end
                    else if (mask_reg[4'(cnt_reg)] && (len_reg[trk] != '0)
                             && (tempo_reg != '0))
                    begin
                        state_reg <= S_RD1;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end

                S_RD1:
                begin
                    // duration = beats * 60 * rate / tempo
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= DVD_W'(rd_beats) * DUR_K_V;
                    div_req_reg.divisor  <= DVS_W'(tempo_reg);
                    state_reg            <= S_DURW;
                end

                S_DURW:
                begin
                    if (div_rsp.done)
                    begin
                        dur_reg <= q_dur;
                        if (elapsed >= TICK_W'(q_dur))
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= DVD_W'(pos_reg[trk]) + 1'b1;
                            div_req_reg.divisor  <= DVS_W'(len_reg[trk]);
                            state_reg            <= S_ADVW;
                        end
                        else
                        begin
                            state_reg <= S_RD2;
                        end
                    end
                end

                S_ADVW:
                begin
                    if (div_rsp.done)
                    begin
                        pos_reg[trk]   <= div_rsp.remainder[POS_W-1:0];
                        start_reg[trk] <= now_reg;
                        env_reg[trk]   <= '0;
                        state_reg      <= S_RD2;
                    end
                end

                S_RD2:
                begin
                    // reread at the (possibly new) position
                    state_reg <= S_FRQ;
                end

                S_FRQ:
                begin
                    if (rd_freq == '0)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= SR_V << octave_reg;
                        div_req_reg.divisor  <= DVS_W'(rd_freq);
                        state_reg            <= S_SPPW;
                    end
                end

                S_SPPW:
                begin
                    if (div_rsp.done)
                    begin
                        spp_reg <= div_rsp.quotient[SPP_W-1:0];
                        if ((div_rsp.quotient == '0) || (dur_reg == '0))
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            // phase offset wraps with the tick counter
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <=
                                DVD_W'(TICK_W'(now_reg + TICK_W'({cnt_reg, 1'b0})));
                            div_req_reg.divisor  <= DVS_W'(div_rsp.quotient[SPP_W-1:0]);
                            state_reg            <= S_PHW;
                        end
                    end
                end

                S_PHW:
                begin
                    if (div_rsp.done)
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= DVD_W'({div_rsp.remainder, 5'd0});
                        div_req_reg.divisor  <= DVS_W'(spp_reg);
                        state_reg            <= S_WIW;
                    end
                end

                S_WIW:
                begin
                    if (div_rsp.done)
                    begin
                        // wave index kept in prod_reg low bits until the gain is back
                        prod_reg <= PROD_W'(div_rsp.quotient[4:0]);
                        if (env_cur != '1)
                        begin
                            env_reg[trk] <= env_cur + 1'b1;
                        end
                        if (DUR_W'(env_cur) >= dur_reg)
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <=
                                {DVD_W'(dur_reg - DUR_W'(env_cur))} << 10;
                            div_req_reg.divisor  <= DVS_W'(dur_reg);
                            state_reg            <= S_GW;
                        end
                    end
                end

                S_GW:
                begin
                    if (div_rsp.done)
                    begin
                        prod_reg  <= PROD_W'(SINE_ROM[prod_reg[4:0]]
                                     * div_rsp.quotient[GAIN_W-1:0]);
                        state_reg <= S_ACC;
                    end
                end

                S_ACC:
                begin
                    sum_reg   <= sum_reg + SUM_W'(prod_reg[PROD_W-1:10]);
                    state_reg <= S_NEXT;
                end

                S_NEXT:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_CHK;
                end

                S_MIX:
                begin
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= DVD_W'(sum_reg);
                    div_req_reg.divisor  <= DVS_W'(count);
                    state_reg            <= S_MIXW;
                end

                S_MIXW:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg <= div_rsp.quotient[SMP_W-1:0];
                        state_reg  <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        mixed_reg     <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;

endmodule
